### src/koon_pkg.sv
// ----------------------------------------------------------------------------
// koon_pkg: shared types and constants
// Defaults, configuration register codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package koon_pkg;

    localparam int MAX_COMPONENTS_DEF = 32;
    localparam int FRAC_BITS_DEF      = 32;
    localparam int COEF_W             = 32;
    localparam int CFG_W              = 6;
    localparam int CFG_IDX_W          = 2;
    localparam int INDEX_W            = 6;
    localparam int SUM_W              = 63;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COMPONENTS = 2'd0,
        CFG_MIN_COMPONENTS = 2'd1,
        CFG_FAILURE_MODE   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PGET,
        ST_TERM,
        ST_MUL,
        ST_MGET,
        ST_SCALE,
        ST_ROT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

### src/koon_if.sv
// ----------------------------------------------------------------------------
// koon_if: item channels
// Sample/load channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface koon_in_if #(
    parameter int FRAC_BITS = koon_pkg::FRAC_BITS_DEF
);
    import koon_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [INDEX_W-1:0]   coef_index;
    logic [COEF_W-1:0]    coef_value;
    logic [FRAC_BITS:0]   reliability_in;

    modport source (output valid, operation, coef_index, coef_value, reliability_in,
                    input ready);
    modport sink (input valid, operation, coef_index, coef_value, reliability_in,
                  output ready);
endinterface

interface koon_out_if #(
    parameter int FRAC_BITS = koon_pkg::FRAC_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] system_reliability;

    modport source (output valid, system_reliability, input ready);
    modport sink (input valid, system_reliability, output ready);
endinterface

### src/koon_cell.sv
// ----------------------------------------------------------------------------
// koon_cell: one coefficient cell
// Holds one table entry; loads directly or takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module koon_cell (
    input  logic                      clk,
    input  koon_pkg::cell_ctrl_t      ctrl,
    input  logic [koon_pkg::COEF_W-1:0] load_value,
    input  logic [koon_pkg::COEF_W-1:0] shift_in,
    output logic [koon_pkg::COEF_W-1:0] value
);
    import koon_pkg::*;

    logic [COEF_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= load_value;
        end
        else if (ctrl.shift)
        begin
            value_reg <= shift_in;
        end
    end

    assign value = value_reg;

endmodule

### src/identical_koon_reliability.sv
// ----------------------------------------------------------------------------
// identical_koon_reliability: K-out-of-N reliability, identical components
// Q1.FRAC_BITS system reliability from one component reliability per item.
// ----------------------------------------------------------------------------
// items carries either a coefficient load (operation=1, no result)
// or a reliability sample (operation=0, one result on results).
// Coefficients sit in a ring of MAX_COMPONENTS+1 cells; during a sample the
// ring rotates one place per term so cell 0 always holds the current one, and
// it is turned a full lap so it is back home when the item ends.
// One shared multiplier does every product: multiply, then round or accumulate.
// Each term multiplies a times by p = r(1-r) and b times by s, then by its
// coefficient, with a = N-K-i and b = max(0, 2(K+i)-N); one item is in
// flight at a time.
// A finished result waits in an output register; the next item is taken
// while it waits, and the sequencer only holds at its last step if the
// previous result has still not been taken.
// Reset clears control and config (N=2, K=1, success mode); the coefficient
// table is undefined until loaded. Config writes take effect at once.
// ----------------------------------------------------------------------------
module identical_koon_reliability #(
    parameter int MAX_COMPONENTS = koon_pkg::MAX_COMPONENTS_DEF,
    parameter int FRAC_BITS      = koon_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [koon_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [koon_pkg::CFG_W-1:0]     cfg_data,
    koon_in_if.sink                        items,
    koon_out_if.source                     results
);
    import koon_pkg::*;

    localparam int DEPTH = MAX_COMPONENTS + 1;
    localparam int FW    = FRAC_BITS + 1;
    localparam int MW    = (FW > COEF_W) ? FW : COEF_W;
    localparam int PW    = 2 * MW;
    localparam int CW    = $clog2(MAX_COMPONENTS + 2);
    localparam int KW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int RW    = $clog2(DEPTH + 1);
    localparam int CIW   = (INDEX_W > CW) ? INDEX_W + 1 : CW + 1;

    localparam logic [FW-1:0]  ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]  HALF_FX = PW'(1) << (FRAC_BITS - 1);
    localparam logic [SUM_W:0] SUM_CAP = (SUM_W + 1)'(1) << (SUM_W - 1);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  num_reg, num_next;
    logic [CFG_W-1:0]  min_reg, min_next;
    logic              fail_reg, fail_next;
    logic [FW-1:0]     r_reg, r_next;
    logic [FW-1:0]     s_reg, s_next;
    logic [FW-1:0]     p_reg, p_next;
    logic [FW-1:0]     prod_reg, prod_next;
    logic [PW-1:0]     mul_reg, mul_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     a_reg, a_next;
    logic [CW-1:0]     b_reg, b_next;
    logic [RW-1:0]     rot_reg, rot_next;
    logic              out_valid_reg, out_valid_next;
    logic [FW-1:0]     out_data_reg, out_data_next;

    logic [MW-1:0]     mul_a, mul_b;
    logic [PW:0]       rnd_sum;
    logic [FW-1:0]     rounded;
    logic [SUM_W-1:0]  term;
    logic [SUM_W:0]    acc;
    logic [FW-1:0]     r_sat;
    logic [KW-1:0]     n_full, n_lim, k_full;
    logic [CW-1:0]     a_tmp;
    logic [FW-1:0]     final_val;
    logic              load_fire;
    logic              shift_en;
    logic [COEF_W-1:0] coef_chain [DEPTH];
    cell_ctrl_t        cell_ctrl [DEPTH];

    // coefficient ring
    genvar c;
    generate
        for (c = 0; c < DEPTH; c++)
        begin : g_cell
            assign cell_ctrl[c].load  = load_fire && (CIW'(items.coef_index) == CIW'(c));
            assign cell_ctrl[c].shift = shift_en;
            koon_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[c]),
                .load_value (items.coef_value),
                .shift_in   (coef_chain[(c + 1) % DEPTH]),
                .value      (coef_chain[c])
            );
        end
    endgenerate

    assign mul_next  = PW'(mul_a) * PW'(mul_b);
    assign rnd_sum   = {1'b0, mul_reg} + {1'b0, HALF_FX};
    assign rounded   = rnd_sum[FRAC_BITS +: FW];
    assign term      = (mul_reg > PW'(SUM_CAP)) ? SUM_CAP[SUM_W-1:0] : mul_reg[SUM_W-1:0];
    assign acc       = {1'b0, sum_reg} + {1'b0, term};
    assign r_sat     = (items.reliability_in > ONE_FX) ? ONE_FX : items.reliability_in;
    assign n_full    = KW'(num_reg);
    assign n_lim     = (n_full > KW'(MAX_COMPONENTS)) ? KW'(MAX_COMPONENTS) : n_full;
    assign k_full    = KW'(min_reg);
    assign a_tmp     = n_reg - j_reg;

    always_comb
    begin
        if (!fail_reg)
        begin
            final_val = (sum_reg > SUM_W'(ONE_FX)) ? ONE_FX : sum_reg[FW-1:0];
        end
        else
        begin
            final_val = (sum_reg >= SUM_W'(ONE_FX)) ? '0 : ONE_FX - sum_reg[FW-1:0];
        end
    end

    // config registers
    always_comb
    begin
        num_next  = num_reg;
        min_next  = min_reg;
        fail_next = fail_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_COMPONENTS: num_next  = cfg_data;
                CFG_MIN_COMPONENTS: min_next  = cfg_data;
                CFG_FAILURE_MODE:   fail_next = cfg_data[0];
                default:            ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rot_next       = rot_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !results.ready;
        mul_a          = MW'(prod_reg);
        mul_b          = MW'(p_reg);
        items.ready    = 1'b0;
        load_fire      = 1'b0;
        shift_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                begin
                    if (items.operation == OP_LOAD)
                    begin
                        load_fire = 1'b1;
                    end
                    else
                    begin
                        r_next   = r_sat;
                        s_next   = fail_reg ? ONE_FX - r_sat : r_sat;
                        n_next   = CW'(n_lim);
                        // no terms when K exceeds N
                        j_next   = (k_full <= n_lim) ? CW'(k_full) : CW'(n_lim) + CW'(1);
                        sum_next = '0;
                        rot_next = '0;
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_PMUL:
            begin
                mul_a      = MW'(r_reg);
                mul_b      = MW'(ONE_FX - r_reg);
                state_next = ST_PGET;
            end
            ST_PGET:
            begin
                p_next     = rounded;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                if (j_reg > n_reg)
                begin
                    state_next = ST_ROT;
                end
                else
                begin
                    a_next     = a_tmp;
                    b_next     = (j_reg > a_tmp) ? j_reg - a_tmp : '0;
                    prod_next  = ONE_FX;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (a_reg != '0)
                begin
                    a_next     = a_reg - CW'(1);
                    state_next = ST_MGET;
                end
                else if (b_reg != '0)
                begin
                    mul_b      = MW'(s_reg);
                    b_next     = b_reg - CW'(1);
                    state_next = ST_MGET;
                end
                else
                begin
                    mul_b      = MW'(coef_chain[0]);
                    state_next = ST_SCALE;
                end
            end
            ST_MGET:
            begin
                prod_next  = rounded;
                state_next = ST_MUL;
            end
            ST_SCALE:
            begin
                sum_next   = (acc > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : acc[SUM_W-1:0];
                shift_en   = 1'b1;
                rot_next   = rot_reg + RW'(1);
                j_next     = j_reg + CW'(1);
                state_next = ST_TERM;
            end
            ST_ROT:
            begin
                // finish the lap so entry 0 is back in cell 0
                if (rot_reg == RW'(DEPTH))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    shift_en = 1'b1;
                    rot_next = rot_reg + RW'(1);
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_data_next  = final_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_reg       <= CFG_W'(2);
            min_reg       <= CFG_W'(1);
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rot_reg       <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            num_reg       <= num_next;
            min_reg       <= min_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        s_reg        <= s_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        mul_reg      <= mul_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign results.valid              = out_valid_reg;
    assign results.system_reliability = out_data_reg;

    // ring never turns more than one lap
    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rot_reg <= RW'(DEPTH))
        else $error("coefficient ring over-rotated");

    // result appears only from the final step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside final step");

    // term index never runs past N while a term is formed
    a_term_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SCALE) |-> j_reg <= n_reg)
        else $error("term index beyond N");

endmodule

### dv/tb_identical_koon_reliability.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_identical_koon_reliability: self-checking bench for the K-out-of-N block
// Loads the coefficient table and sends reliability samples over a range of
// N, K and mode settings. Each result is checked against an in-bench
// fixed-point prediction or a typed expected value. Both channels idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_identical_koon_reliability;
    import koon_pkg::*;

    localparam int          TABLE_DEPTH = MAX_COMPONENTS_DEF + 1;
    localparam logic [32:0] ONE_FX      = 33'h1_0000_0000;
    localparam logic [63:0] SUM_CAP     = 64'h4000_0000_0000_0000;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct {
        op_t         op;
        logic [5:0]  idx;
        logic [31:0] val;
        logic [32:0] rel;
        bit          typed;
        logic [32:0] want;
    } stim_row_t;

    typedef struct {
        int n;
        int k;
        int mode;
        int count;
    } setting_t;

    typedef struct {
        bit          typed;
        logic [32:0] want;
    } typed_want_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    cfg_index_t     cfg_index;
    logic [CFG_W-1:0] cfg_data;

    koon_in_if  in_ch();
    koon_out_if out_ch();

    identical_koon_reliability dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .items    (in_ch),
        .results  (out_ch)
    );

    // configuration and coefficient mirrors
    logic [5:0]  n_cfg;
    logic [5:0]  k_cfg;
    logic        mode_cfg;
    logic [31:0] coef_mirror[TABLE_DEPTH];

    logic [32:0] reliability_due[$];
    typed_want_t typed_wants[$];

    int fails;
    int accepted;
    int samples_sent;
    int loads_sent;
    int results_seen;
    int cycles;
    bit hold_req;
    bit hold_done;
    int hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [32:0] round_mul(logic [32:0] a, logic [32:0] b);
        logic [67:0] full;
        full = {35'd0, a} * {35'd0, b} + 68'h8000_0000;
        return full[64:32];
    endfunction

    function automatic logic [32:0] system_reliability_of(logic [32:0] rel_in);
        logic [32:0] r;
        logic [32:0] u;
        logic [32:0] p;
        logic [32:0] prod;
        logic [32:0] single;
        logic [63:0] sum;
        logic [64:0] acc;
        logic [64:0] term;
        int          n;
        int          k;
        int          w;
        int          f;
        r = (rel_in > ONE_FX) ? ONE_FX : rel_in;
        u = ONE_FX - r;
        p = round_mul(r, u);
        n = (n_cfg > MAX_COMPONENTS_DEF) ? MAX_COMPONENTS_DEF : int'(n_cfg);
        k = int'(k_cfg);
        single = mode_cfg ? u : r;
        sum = '0;
        if (k <= n)
        begin
            for (int i = 0; i <= n - k; i++)
            begin
                prod = ONE_FX;
                if (!mode_cfg)
                begin
                    w = k + i;
                    f = n - k - i;
                    for (int e = 0; e < f; e++) prod = round_mul(prod, p);
                    for (int e = f; e < w; e++) prod = round_mul(prod, single);
                end
                else
                begin
                    w = n - k - i;
                    f = k + i;
                    for (int e = 0; e < w; e++) prod = round_mul(prod, p);
                    for (int e = w; e < f; e++) prod = round_mul(prod, single);
                end
                term = {33'd0, coef_mirror[i]} * {32'd0, prod};
                if (term > {1'b0, SUM_CAP}) term = {1'b0, SUM_CAP};
                acc = {1'b0, sum} + term;
                sum = (acc > {1'b0, SUM_CAP}) ? SUM_CAP : acc[63:0];
            end
        end
        if (!mode_cfg)
            return (sum > {31'd0, ONE_FX}) ? ONE_FX : sum[32:0];
        else
            return (sum >= {31'd0, ONE_FX}) ? 33'd0 : ONE_FX - sum[32:0];
    endfunction

    function automatic int idle_regime();
        return (accepted < 270) ? 0 : (accepted < 540) ? 1 : 2;
    endfunction

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_identical_koon_reliability NOT OK");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        int pct;
        pct = (idle_regime() == 0) ? 55 : (idle_regime() == 1) ? 38 : 0;
        if (hold_cnt > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= pct);
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        typed_want_t tw;
        logic [32:0] want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                accepted <= accepted + 1;
                if (accepted == 150) hold_req <= 1'b1;
                tw.typed = 1'b0;
                tw.want = '0;
                if (typed_wants.size() > 0) tw = typed_wants.pop_front();
                if (in_ch.operation == OP_LOAD)
                begin
                    if (in_ch.coef_index < TABLE_DEPTH)
                        coef_mirror[in_ch.coef_index] = in_ch.coef_value;
                end
                else if (tw.typed)
                    reliability_due.push_back(tw.want);
                else
                    reliability_due.push_back(system_reliability_of(in_ch.reliability_in));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (reliability_due.size() == 0)
                begin
                    $error("unexpected result system_reliability=%h",
                           out_ch.system_reliability);
                    fails <= fails + 1;
                end
                else
                begin
                    want = reliability_due.pop_front();
                    if (out_ch.system_reliability !== want)
                    begin
                        $error("system_reliability: expected %h, got %h",
                               want, out_ch.system_reliability);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

    task automatic send_item(op_t op, logic [5:0] idx, logic [31:0] val, logic [32:0] rel);
        int pct;
        pct = (idle_regime() == 0) ? 38 : (idle_regime() == 1) ? 55 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.coef_index     <= idx;
        in_ch.coef_value     <= val;
        in_ch.reliability_in <= rel;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (op == OP_LOAD) loads_sent++;
        else samples_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (reliability_due.size() != 0) @(posedge clk);
        // extra idle margin before the next setting
        repeat (16) @(posedge clk);
    endtask

    task automatic write_config(int n, int k, int mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_COMPONENTS;
        cfg_data  <= n[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_MIN_COMPONENTS;
        cfg_data  <= k[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_FAILURE_MODE;
        cfg_data  <= CFG_W'(mode);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_cfg    = n[5:0];
        k_cfg    = k[5:0];
        mode_cfg = mode[0];
    endtask

    task automatic random_items(int count);
        logic [31:0] val;
        logic [32:0] rel;
        int          roll;
        for (int j = 0; j < count; j++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                roll = $urandom_range(0, 9);
                val = (roll < 5) ? $urandom_range(0, 40) :
                      (roll < 8) ? $urandom_range(0, 1000) : $urandom();
                send_item(OP_LOAD, 6'($urandom_range(0, 63)), val, 33'($urandom()));
            end
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    rel = {1'($urandom_range(0, 1)), 32'($urandom())};
                else if (roll == 1)
                    rel = $urandom_range(0, 1) ? ONE_FX : 33'd0;
                else
                    rel = {1'b0, 32'($urandom())};
                send_item(OP_SAMPLE, 6'($urandom()), $urandom(), rel);
            end
        end
    endtask

    stim_row_t directed[$];
    setting_t  settings[$];

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_NUM_COMPONENTS;
        cfg_data  = '0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_SAMPLE;
        in_ch.coef_index     = '0;
        in_ch.coef_value     = '0;
        in_ch.reliability_in = '0;
        out_ch.ready = 1'b0;
        fails = 0; accepted = 0; samples_sent = 0; loads_sent = 0;
        results_seen = 0; cycles = 0;
        hold_req = 1'b0; hold_done = 1'b0; hold_cnt = 0;
        n_cfg = 6'd2; k_cfg = 6'd1; mode_cfg = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) coef_mirror[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry before any sample reads it
        for (int i = 0; i < TABLE_DEPTH; i++) send_item(OP_LOAD, 6'(i), 32'd1, '0);

        // let the last fill load be taken before typed rows queue up
        in_ch.valid <= 1'b0;
        @(posedge clk);

        // reset config: N=2, K=1, success; coef0=2, coef1=1
        directed = '{
            '{OP_LOAD,   6'd0,  32'd2,        33'd0,            0, 33'd0},
            '{OP_LOAD,   6'd1,  32'd1,        33'd0,            0, 33'd0},
            '{OP_LOAD,   6'd33, 32'hFFFF_FFFF, 33'd0,           0, 33'd0},
            '{OP_LOAD,   6'd63, 32'hFFFF_FFFF, 33'd0,           0, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'd0,            1, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        ONE_FX,           1, ONE_FX},
            '{OP_SAMPLE, 6'd63, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 1, ONE_FX},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h1_0000_0001,  1, ONE_FX},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h0_8000_0000,  0, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h0_0000_0001,  0, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h0_FFFF_FFFF,  0, 33'd0},
            '{OP_LOAD,   6'd0,  32'hFFFF_FFFF, 33'd0,           0, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h0_8000_0000,  0, 33'd0},
            '{OP_LOAD,   6'd0,  32'd2,        33'd0,            0, 33'd0},
            '{OP_SAMPLE, 6'd0,  32'd0,        33'h0_C000_0000,  0, 33'd0}
        };
        foreach (directed[i])
        begin
            typed_wants.push_back('{directed[i].typed, directed[i].want});
            send_item(directed[i].op, directed[i].idx, directed[i].val, directed[i].rel);
        end

        // extremes: N above max, K above N, zero N/K, full size
        settings = '{
            '{5, 3, 0, 100}, '{5, 3, 1, 100}, '{1, 1, 0, 50}, '{32, 1, 0, 6},
            '{32, 32, 1, 6}, '{32, 16, 1, 6}, '{63, 40, 0, 20}, '{63, 1, 1, 4},
            '{4, 6, 1, 30}, '{0, 0, 0, 30}, '{8, 0, 1, 60}, '{0, 0, 1, 30},
            '{3, 2, 1, 80}, '{6, 1, 0, 80}, '{10, 7, 1, 80}, '{7, 4, 0, 80},
            '{2, 1, 0, 40}
        };
        foreach (settings[i])
        begin
            settle();
            write_config(settings[i].n, settings[i].k, settings[i].mode);
            random_items(settings[i].count);
        end

        settle();
        repeat (50) @(posedge clk);
        $display("covered %0d samples and %0d loads over %0d settings, %0d results checked",
                 samples_sent, loads_sent, settings.size() + 1, results_seen);
        if (fails == 0)
            $display("tb_identical_koon_reliability OK");
        else
            $display("tb_identical_koon_reliability NOT OK");
        $finish;
    end

endmodule
